// ===== src/mcdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mcdf_pkg
// Shared types, codes and defaults of the length-prefixed deframer.
// ============================================================================
package mcdf_pkg;

    localparam int NUM_CONNECTIONS_DEF = 64;
    localparam int HEADER_BYTES_DEF    = 4;
    localparam int HEADER_BYTES_MAX    = 8;

    localparam int MODE_W    = 2;
    localparam int CONN_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int PHASE_W   = 2;
    localparam int LEN_W     = 24;
    localparam int GATHER_W  = 32;
    localparam int HDR_CNT_W = $clog2(HEADER_BYTES_MAX + 1);

    localparam logic [LEN_W-1:0] MAX_BODY_RESET = 24'd65536;

    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

    localparam logic [PHASE_W-1:0] PH_CLOSED  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BODY    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DROPPED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_BYTE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERSIZE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ABORT    = 2'd3;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic [HDR_CNT_W-1:0] header_count;
        logic [GATHER_W-1:0]  length_gather;
        logic [LEN_W-1:0]     body_remaining;
    } conn_state_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] body_byte;
        logic              last;
    } result_t;

endpackage
`default_nettype wire

// ===== src/multi_connection_length_prefix_deframer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// multi_connection_length_prefix_deframer_unit
// Per-connection deframer for big-endian length-prefixed frames.
// ============================================================================
// The block accepts one beat per cycle unless out_ready stalls a result and
// passes its result, if any, through the update stage and output register.
// Throughput is set by the single read-modify-write of the connection state
// memory: the state is read at acceptance, updated in the update stage and
// written back, with a bypass when consecutive beats hit the same connection.
// After reset a clearing pass zeroes all NUM_CONNECTIONS state entries and
// in_ready stays low until then; configuration writes are taken throughout.
module multi_connection_length_prefix_deframer_unit #(
    parameter int NUM_CONNECTIONS = mcdf_pkg::NUM_CONNECTIONS_DEF,
    parameter int HEADER_BYTES    = mcdf_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [mcdf_pkg::LEN_W-1:0]   cfg_write_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [mcdf_pkg::MODE_W-1:0]  mode,
    input  wire logic [mcdf_pkg::CONN_W-1:0]  conn_id,
    input  wire logic [mcdf_pkg::BYTE_W-1:0]  data_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [mcdf_pkg::CONN_W-1:0]       out_conn,
    output logic [mcdf_pkg::KIND_W-1:0]       kind,
    output logic [mcdf_pkg::BYTE_W-1:0]       body_byte,
    output logic                              last
);
    import mcdf_pkg::*;

    localparam int ADDR_W = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;

    logic [LEN_W-1:0]  max_body_reg;

    logic              in_fire;
    logic [ADDR_W-1:0] in_addr;
    logic              in_id_ok;

    logic              s1_valid_reg;
    logic [MODE_W-1:0] s1_mode_reg;
    logic [CONN_W-1:0] s1_conn_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_id_ok_reg;
    logic              s1_adv;

    logic              bypass_reg;
    conn_state_t       bypass_data_reg;
    conn_state_t       rd_data;
    conn_state_t       cur_state;
    conn_state_t       next_state;
    result_t           result;
    logic              mem_we;
    logic              clr_busy;
    logic              out_load;

    logic              out_valid_reg;
    logic [CONN_W-1:0] out_conn_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg <= MAX_BODY_RESET;
        end
        else if (cfg_write_en)
        begin
            max_body_reg <= cfg_write_data;
        end
    end

    assign in_id_ok = (32'(conn_id) < NUM_CONNECTIONS);
    assign in_addr  = ADDR_W'(conn_id);

    assign out_load = s1_valid_reg && s1_id_ok_reg && result.valid && s1_adv;
    assign s1_adv   = !(s1_id_ok_reg && result.valid) || !out_valid_reg || out_ready;
    assign in_ready = !clr_busy && (!s1_valid_reg || s1_adv);
    assign in_fire  = in_valid && in_ready;
    assign mem_we   = s1_valid_reg && s1_id_ok_reg && s1_adv;

    mcdf_state_mem #(
        .NUM_CONNECTIONS(NUM_CONNECTIONS),
        .ADDR_W         (ADDR_W)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (s1_addr_reg),
        .wr_data (next_state),
        .clr_busy(clr_busy)
    );

    assign cur_state = bypass_reg ? bypass_data_reg : rd_data;

    mcdf_update #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_update (
        .mode           (s1_mode_reg),
        .data_byte      (s1_byte_reg),
        .max_body_length(max_body_reg),
        .cur_state      (cur_state),
        .next_state     (next_state),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            bypass_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                bypass_reg   <= mem_we && (s1_addr_reg == in_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg     <= mode;
            s1_conn_reg     <= conn_id;
            s1_addr_reg     <= in_addr;
            s1_byte_reg     <= data_byte;
            s1_id_ok_reg    <= in_id_ok;
            bypass_data_reg <= next_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_conn_reg <= s1_conn_reg;
            out_kind_reg <= result.kind;
            out_byte_reg <= result.body_byte;
            out_last_reg <= result.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_conn  = out_conn_reg;
    assign kind      = out_kind_reg;
    assign body_byte = out_byte_reg;
    assign last      = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !in_ready)
    else $error("Beat accepted during the clearing pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mem_we && (s1_addr_reg == in_addr)) |=> bypass_reg)
    else $error("Back-to-back beats on one connection missed the bypass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_conn_reg)))
    else $error("Stalled update stage lost its beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg != KIND_BYTE) |-> (out_byte_reg == '0))
    else $error("Non-byte result carries a body byte.");

endmodule
`default_nettype wire

// ===== src/mcdf_state_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mcdf_state_mem
// Per-connection state memory with one write port, one registered read port
// and a clearing pass after reset.
// ============================================================================
module mcdf_state_mem #(
    parameter int NUM_CONNECTIONS = mcdf_pkg::NUM_CONNECTIONS_DEF,
    parameter int ADDR_W          = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output mcdf_pkg::conn_state_t     rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire mcdf_pkg::conn_state_t wr_data,
    output logic                      clr_busy
);
    import mcdf_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CONNECTIONS - 1);

    conn_state_t       mem [NUM_CONNECTIONS];
    conn_state_t       rd_data_reg;
    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire

// ===== src/mcdf_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mcdf_update
// Next-state and result logic for one event on one connection.
// ============================================================================
module mcdf_update #(
    parameter int HEADER_BYTES = mcdf_pkg::HEADER_BYTES_DEF
) (
    input  wire logic [mcdf_pkg::MODE_W-1:0] mode,
    input  wire logic [mcdf_pkg::BYTE_W-1:0] data_byte,
    input  wire logic [mcdf_pkg::LEN_W-1:0]  max_body_length,
    input  wire mcdf_pkg::conn_state_t       cur_state,
    output mcdf_pkg::conn_state_t            next_state,
    output mcdf_pkg::result_t                result
);
    import mcdf_pkg::*;

    localparam logic [HDR_CNT_W-1:0] HDR_END = HDR_CNT_W'(HEADER_BYTES);

    logic [GATHER_W-1:0]  gather_next;
    logic [HDR_CNT_W-1:0] count_next;
    logic [LEN_W-1:0]     remain_next;
    logic                 partial;

    always_comb
    begin
        if (cur_state.length_gather[GATHER_W-1:GATHER_W-8] != 8'd0)
        begin
            gather_next = '1;
        end
        else
        begin
            gather_next = {cur_state.length_gather[GATHER_W-9:0], data_byte};
        end
        count_next  = cur_state.header_count + 1'b1;
        remain_next = cur_state.body_remaining - 1'b1;
        partial     = (cur_state.phase == PH_BODY) ||
                      (cur_state.phase == PH_HEADER && cur_state.header_count != '0);

        next_state = cur_state;
        result     = '0;

        unique case (mode)
            MODE_OPEN:
            begin
                next_state       = '0;
                next_state.phase = PH_HEADER;
            end
            MODE_CLOSE:
            begin
                next_state = '0;
                if (partial)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_ABORT;
                end
            end
            MODE_DATA:
            begin
                if (cur_state.phase == PH_HEADER)
                begin
                    if (count_next < HDR_END)
                    begin
                        next_state.header_count  = count_next;
                        next_state.length_gather = gather_next;
                    end
                    else
                    begin
                        next_state.header_count  = '0;
                        next_state.length_gather = '0;
                        if (gather_next > {8'd0, max_body_length})
                        begin
                            next_state       = '0;
                            next_state.phase = PH_DROPPED;
                            result.valid     = 1'b1;
                            result.kind      = KIND_OVERSIZE;
                        end
                        else if (gather_next == '0)
                        begin
                            result.valid = 1'b1;
                            result.kind  = KIND_EMPTY;
                            result.last  = 1'b1;
                        end
                        else
                        begin
                            next_state.body_remaining = gather_next[LEN_W-1:0];
                            next_state.phase          = PH_BODY;
                        end
                    end
                end
                else if (cur_state.phase == PH_BODY)
                begin
                    next_state.body_remaining = remain_next;
                    result.valid     = 1'b1;
                    result.kind      = KIND_BYTE;
                    result.body_byte = data_byte;
                    if (remain_next == '0)
                    begin
                        next_state       = '0;
                        next_state.phase = PH_HEADER;
                        result.last      = 1'b1;
                    end
                end
            end
            default:
            begin
                next_state = cur_state;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== test/deframer_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// deframer_checker
// Watches the beat, result and register ports of the length-prefixed
// deframer. It keeps its own per-connection copy of the frame state and
// predicts the result of every accepted input beat. Each accepted output
// beat is compared field by field with the oldest prediction. It reports
// the mismatch count and the number of results still outstanding.
// ============================================================================
module deframer_checker
    import mcdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [LEN_W-1:0]  cfg_write_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [MODE_W-1:0] mode,
    input  logic [CONN_W-1:0] conn_id,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CONN_W-1:0] out_conn,
    input  logic [KIND_W-1:0] kind,
    input  logic [BYTE_W-1:0] body_byte,
    input  logic              last,
    output int                mismatches,
    output int                pending,
    output int                results_seen
);

    typedef struct packed {
        logic [CONN_W-1:0] conn;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] body_byte;
        logic              last;
    } deframe_result_t;

    logic [PHASE_W-1:0]  conn_phase [NUM_CONNECTIONS_DEF];
    int                  hdr_count  [NUM_CONNECTIONS_DEF];
    logic [GATHER_W-1:0] len_gather [NUM_CONNECTIONS_DEF];
    logic [LEN_W-1:0]    body_left  [NUM_CONNECTIONS_DEF];
    logic [LEN_W-1:0]    max_len;

    deframe_result_t expected_results [$];
    int              fail_count;
    int              result_count;

    task automatic clear_frame(input logic [CONN_W-1:0] c);
        hdr_count[c]  = 0;
        len_gather[c] = '0;
        body_left[c]  = '0;
    endtask

    task automatic deframe_beat(input logic [MODE_W-1:0] m, input logic [CONN_W-1:0] c,
                                input logic [BYTE_W-1:0] b);
        deframe_result_t     res;
        logic [GATHER_W-1:0] g;
        logic                produced;
        logic                partial;
        res.conn      = c;
        res.kind      = KIND_BYTE;
        res.body_byte = '0;
        res.last      = 1'b0;
        produced      = 1'b0;
        case (m)
            MODE_OPEN:
            begin
                conn_phase[c] = PH_HEADER;
                clear_frame(c);
            end
            MODE_CLOSE:
            begin
                partial = (conn_phase[c] == PH_BODY) ||
                          (conn_phase[c] == PH_HEADER && hdr_count[c] != 0);
                conn_phase[c] = PH_CLOSED;
                clear_frame(c);
                if (partial)
                begin
                    res.kind = KIND_ABORT;
                    produced = 1'b1;
                end
            end
            MODE_DATA:
            begin
                if (conn_phase[c] == PH_HEADER)
                begin
                    g = len_gather[c];
                    if (g[GATHER_W-1:24] != '0)
                        g = '1;
                    else
                        g = {g[23:0], b};
                    len_gather[c] = g;
                    hdr_count[c]  = hdr_count[c] + 1;
                    if (hdr_count[c] >= HEADER_BYTES_DEF)
                    begin
                        hdr_count[c]  = 0;
                        len_gather[c] = '0;
                        if (g > {8'd0, max_len})
                        begin
                            conn_phase[c] = PH_DROPPED;
                            clear_frame(c);
                            res.kind = KIND_OVERSIZE;
                            produced = 1'b1;
                        end
                        else if (g == '0)
                        begin
                            res.kind = KIND_EMPTY;
                            res.last = 1'b1;
                            produced = 1'b1;
                        end
                        else
                        begin
                            body_left[c]  = g[LEN_W-1:0];
                            conn_phase[c] = PH_BODY;
                        end
                    end
                end
                else if (conn_phase[c] == PH_BODY)
                begin
                    body_left[c] = body_left[c] - 24'd1;
                    if (body_left[c] == '0)
                    begin
                        res.last      = 1'b1;
                        conn_phase[c] = PH_HEADER;
                        clear_frame(c);
                    end
                    res.body_byte = b;
                    produced      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (produced)
            expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deframe_result_t exp_res;
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CONNECTIONS_DEF; c++)
            begin
                conn_phase[c] = PH_CLOSED;
                clear_frame(CONN_W'(c));
            end
            max_len = MAX_BODY_RESET;
            expected_results.delete();
            fail_count   = 0;
            result_count = 0;
            mismatches   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_beat(mode, conn_id, data_byte);
            if (cfg_write_en)
                max_len = cfg_write_data;
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("Unexpected result beat: conn %0d kind %0d byte %0d last %0d",
                           out_conn, kind, body_byte, last);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("out_conn", 32'(exp_res.conn), 32'(out_conn));
                    check_field("kind", 32'(exp_res.kind), 32'(kind));
                    check_field("body_byte", 32'(exp_res.body_byte), 32'(body_byte));
                    check_field("last", 32'(exp_res.last), 32'(last));
                end
            end
            mismatches   <= fail_count;
            pending      <= expected_results.size();
            results_seen <= result_count;
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus and verdict for the multi-connection length-prefixed deframer.
// A short directed sequence walks through empty, normal, oversize and aborted
// frames, then randomized traffic interleaves well-formed frames on a few
// connections with stray beats, early closes and reopens, under several
// maximum body lengths. Both channels idle and stall at random; the checker
// beside the block predicts and compares every result.
// ============================================================================
module testbench;
    import mcdf_pkg::*;

    localparam int LIMIT_CYCLES    = 250000;
    localparam int BEATS_PER_PHASE = 185;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 24;
    localparam int ACTIVE_COUNT    = 6;
    localparam int PHASE_COUNT     = 6;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [PHASE_COUNT*LEN_W-1:0] PHASE_MAX =
        {24'd16, 24'd0, 24'hFFFFFF, 24'd5, 24'd40, 24'd1};

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic [LEN_W-1:0]  cfg_write_data = '0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [MODE_W-1:0] mode           = MODE_DATA;
    logic [CONN_W-1:0] conn_id        = '0;
    logic [BYTE_W-1:0] data_byte      = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [CONN_W-1:0] out_conn;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] body_byte;
    logic              last;

    int mismatches;
    int pending;
    int results_seen;
    int cycle_count;
    int beats_sent;
    int settings_used;

    logic             src_idle  = 1'b1;
    logic             sink_idle = 1'b1;
    logic [LEN_W-1:0] cur_max   = MAX_BODY_RESET;

    bit          link_open [NUM_CONNECTIONS_DEF];
    int          hdr_todo  [NUM_CONNECTIONS_DEF];
    int          body_todo [NUM_CONNECTIONS_DEF];
    logic [31:0] plan_len  [NUM_CONNECTIONS_DEF];

    always #2 clk = ~clk;

    multi_connection_length_prefix_deframer_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .conn_id        (conn_id),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_conn       (out_conn),
        .kind           (kind),
        .body_byte      (body_byte),
        .last           (last)
    );

    deframer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .conn_id        (conn_id),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_conn       (out_conn),
        .kind           (kind),
        .body_byte      (body_byte),
        .last           (last),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [CONN_W-1:0] c,
                             input logic [BYTE_W-1:0] b);
        int gap;
        gap = src_idle ? int'($urandom_range(0, 16)) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        conn_id   <= c;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // The pending count is registered, so it lags the checker's queue; the task lets it catch up before trusting it.
    task automatic write_max(input logic [LEN_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_max = value;
        settings_used++;
    endtask

    task automatic send_planned(input logic [CONN_W-1:0] c);
        int r;
        int cap;
        if (!link_open[c])
        begin
            send_beat(MODE_OPEN, c, 8'($urandom));
            link_open[c] = 1'b1;
            hdr_todo[c]  = 0;
            body_todo[c] = 0;
        end
        else
        begin
            if (hdr_todo[c] == 0 && body_todo[c] == 0)
            begin
                r   = $urandom_range(0, 99);
                cap = (cur_max < 24'd16) ? int'(cur_max) : 16;
                if (r < 8 || cap == 0)
                    plan_len[c] = '0;
                else if (r < 18)
                    plan_len[c] = {8'd0, cur_max} + 32'($urandom_range(1, 3));
                else if (r < 24)
                    plan_len[c] = $urandom;
                else
                    plan_len[c] = 32'($urandom_range(1, cap));
                hdr_todo[c] = HEADER_BYTES_DEF;
            end
            if (hdr_todo[c] != 0)
            begin
                hdr_todo[c]--;
                send_beat(MODE_DATA, c, plan_len[c][8*hdr_todo[c] +: 8]);
                if (hdr_todo[c] == 0)
                begin
                    if (plan_len[c] > {8'd0, cur_max})
                        link_open[c] = 1'b0;
                    else
                        body_todo[c] = int'(plan_len[c]);
                end
            end
            else
            begin
                body_todo[c]--;
                send_beat(MODE_DATA, c, 8'($urandom));
            end
        end
    endtask

    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++)
            @(posedge clk);
        $display("FAIL multi_connection_length_prefix_deframer_unit");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = sink_idle ? int'($urandom_range(0, 16)) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        logic [CONN_W-1:0] c;
        logic [CONN_W-1:0] active_conns [ACTIVE_COUNT];
        int                r;
        int                planned;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_max(24'd3);

        send_beat(MODE_DATA, 6'd5, 8'hA5);
        send_beat(MODE_UNUSED, 6'd5, 8'h5A);
        send_beat(MODE_OPEN, 6'd0, 8'h00);
        send_beat(MODE_DATA, 6'd0, 8'h12);
        send_beat(MODE_OPEN, 6'd0, 8'hFF);
        repeat (4) send_beat(MODE_DATA, 6'd0, 8'h00);
        repeat (3) send_beat(MODE_DATA, 6'd0, 8'h00);
        send_beat(MODE_DATA, 6'd0, 8'h02);
        send_beat(MODE_DATA, 6'd0, 8'hFF);
        send_beat(MODE_DATA, 6'd0, 8'h00);
        send_beat(MODE_CLOSE, 6'd0, 8'h00);
        send_beat(MODE_OPEN, 6'd63, 8'h00);
        repeat (4) send_beat(MODE_DATA, 6'd63, 8'hFF);
        send_beat(MODE_DATA, 6'd63, 8'h5A);
        send_beat(MODE_OPEN, 6'd63, 8'h00);
        repeat (3) send_beat(MODE_DATA, 6'd63, 8'h00);
        send_beat(MODE_DATA, 6'd63, 8'h03);
        send_beat(MODE_DATA, 6'd63, 8'hAA);
        send_beat(MODE_CLOSE, 6'd63, 8'hFF);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_max(PHASE_MAX[p*LEN_W +: LEN_W]);
            for (int i = 0; i < ACTIVE_COUNT; i++)
                active_conns[i] = CONN_W'($urandom_range(0, NUM_CONNECTIONS_DEF - 1));
            planned = 0;
            while (planned < BEATS_PER_PHASE)
            begin
                if (planned % 64 == 0)
                    {src_idle, sink_idle} = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0)
                    c = CONN_W'($urandom_range(0, NUM_CONNECTIONS_DEF - 1));
                else
                    c = active_conns[$urandom_range(0, ACTIVE_COUNT - 1)];
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    send_beat(MODE_CLOSE, c, 8'($urandom));
                    link_open[c] = 1'b0;
                    hdr_todo[c]  = 0;
                    body_todo[c] = 0;
                    planned++;
                end
                else if (r < 5)
                begin
                    send_beat(MODE_OPEN, c, 8'($urandom));
                    link_open[c] = 1'b1;
                    hdr_todo[c]  = 0;
                    body_todo[c] = 0;
                    planned++;
                end
                else if (r < 7)
                    send_beat(MODE_UNUSED, c, 8'($urandom));
                else if (r < 9)
                    send_beat(MODE_DATA, c, 8'($urandom));
                else
                begin
                    send_planned(c);
                    planned++;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d input beats and checked %0d result beats.", beats_sent,
                 results_seen);
        $display("Traffic ran under %0d maximum body length settings.", settings_used);
        if (mismatches == 0 && pending == 0)
            $display("PASS multi_connection_length_prefix_deframer_unit");
        else
            $display("FAIL multi_connection_length_prefix_deframer_unit");
        $finish;
    end

endmodule
